FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/olr_pkg.sv
`default_nettype none

package olr_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned SHIFT_W  = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;
  // width of the divide step counter (counts SHIFT_W down to 0)
  localparam int unsigned STEP_W   = $clog2(SHIFT_W + 1);

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_REM_LAST = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_AT = 3'd2;
  localparam logic [OP_W-1:0] OP_ROT_L = 3'd3;
  localparam logic [OP_W-1:0] OP_ROT_R = 3'd4;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic                load;       // latch the request payload
    logic                app_wr;     // write value at tail, count up
    logic                cnt_dec;    // count down
    logic                idx_pos;    // index <= position - 1
    logic                idx_zero;   // index <= 0
    logic                rd;         // store read
    logic                rd_next;    // read at index + 1 instead of index
    logic                shift_wr;   // write read data at index, index up
    logic                srch_cmp;   // compare read data, index up
    logic                mod_start;  // start shift_amount mod count
    logic                rot_apply;  // move head slot
    logic                res_load;   // load the result register
    logic [STATUS_W-1:0] res_status;
  } olr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            pos_bad;
    logic            shift_more;
    logic            srch_more;
    logic            mod_done;
    logic            out_free;
  } olr_sts_t;

endpackage

`default_nettype wire

FILE: rtl/olr_if.sv
`default_nettype none

interface olr_in_if
  import olr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [VAL_W-1:0] real_part;
  logic signed [VAL_W-1:0] imag_part;
  logic [POS_W-1:0]        position;
  logic [SHIFT_W-1:0]      shift_amount;

  modport source (
    output valid, opcode, real_part, imag_part, position, shift_amount,
    input  ready
  );
  modport sink (
    input  valid, opcode, real_part, imag_part, position, shift_amount,
    output ready
  );
endinterface

interface olr_out_if
  import olr_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [COUNT_W-1:0]  count_after;

  modport source (
    output valid, status, found, count_after,
    input  ready
  );
  modport sink (
    input  valid, status, found, count_after,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/olr_mod.sv
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module olr_mod
  import olr_pkg::*;
#(
  parameter int unsigned VW = 7
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [SHIFT_W-1:0] dividend_i,
  input  wire logic [VW-1:0]      divisor_i,
  output logic                    done_o,
  output logic [VW-1:0]           rem_o
);

  logic [SHIFT_W-1:0] dvd_q;
  logic [VW-1:0]      rem_q;
  logic [VW:0]        rem_d;
  logic [STEP_W-1:0]  step_q;
  logic               done_q;
  logic [VW:0]        trial;

  always_comb begin
    trial = {rem_q, dvd_q[SHIFT_W-1]};
    if (trial >= {1'b0, divisor_i}) begin
      rem_d = trial - {1'b0, divisor_i};
    end else begin
      rem_d = trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      step_q <= STEP_W'(SHIFT_W);
      done_q <= 1'b0;
    end else if (step_q != '0) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        done_q <= 1'b1;
      end
    end
  end

  // remainder stays below the divisor, so VW bits hold it
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (step_q != '0) begin
      dvd_q <= {dvd_q[SHIFT_W-2:0], 1'b0};
      rem_q <= rem_d[VW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/olr_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module olr_ctrl
  import olr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire olr_sts_t sts_i,
  output olr_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SHCHK = 3'd2;
  localparam logic [2:0] S_SHWR  = 3'd3;
  localparam logic [2:0] S_SRCHK = 3'd4;
  localparam logic [2:0] S_SRCMP = 3'd5;
  localparam logic [2:0] S_ROT   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [STATUS_W-1:0] res_q, res_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        res_d   = ST_DONE;
        state_d = S_FIN;
        unique case (sts_i.op) inside
          OP_APPEND: begin
            if (sts_i.full) begin
              res_d = ST_FULL;
            end else begin
              cmd_o.app_wr = 1'b1;
            end
          end
          OP_REM_LAST: begin
            if (sts_i.empty) begin
              res_d = ST_EMPTY;
            end else begin
              cmd_o.cnt_dec = 1'b1;
            end
          end
          OP_REM_AT: begin
            if (sts_i.empty) begin
              res_d = ST_EMPTY;
            end else if (sts_i.pos_bad) begin
              res_d = ST_RANGE;
            end else begin
              cmd_o.idx_pos = 1'b1;
              state_d       = S_SHCHK;
            end
          end
          OP_ROT_L, OP_ROT_R: begin
            if (sts_i.empty) begin
              res_d = ST_EMPTY;
            end else begin
              cmd_o.mod_start = 1'b1;
              state_d         = S_ROT;
            end
          end
          OP_SEARCH: begin
            cmd_o.idx_zero = 1'b1;
            state_d        = S_SRCHK;
          end
          default: ;
        endcase
      end
      S_SHCHK: begin
        if (sts_i.shift_more) begin
          cmd_o.rd      = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d       = S_SHWR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FIN;
        end
      end
      S_SHWR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHCHK;
      end
      S_SRCHK: begin
        if (sts_i.srch_more) begin
          cmd_o.rd = 1'b1;
          state_d  = S_SRCMP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SRCMP: begin
        cmd_o.srch_cmp = 1'b1;
        state_d        = S_SRCHK;
      end
      S_ROT: begin
        if (sts_i.mod_done) begin
          cmd_o.rot_apply = 1'b1;
          state_d         = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = res_q;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_DONE;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "request accepted but controller still ready")
  `ASSERT_IMPLY(a_res_only_when_free, clk_i, rst_ni, cmd_o.res_load, sts_i.out_free, "result loaded over an untaken result")

endmodule

`default_nettype wire

FILE: rtl/olr_dpath.sv
`default_nettype none
`include "assert_macros.svh"

module olr_dpath
  import olr_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire olr_cmd_t                cmd_i,
  output olr_sts_t                     sts_o,
  input  wire logic [OP_W-1:0]         opcode_i,
  input  wire logic signed [VAL_W-1:0] real_part_i,
  input  wire logic signed [VAL_W-1:0] imag_part_i,
  input  wire logic [POS_W-1:0]        position_i,
  input  wire logic [SHIFT_W-1:0]      shift_amount_i,
  input  wire logic                    out_ready_i,
  output logic                         out_valid_o,
  output logic [STATUS_W-1:0]          status_o,
  output logic                         found_o,
  output logic [COUNT_W-1:0]           count_after_o
);

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned DW = 2 * VAL_W;

  // (base + off) mod CAPACITY, both operands already below CAPACITY
  function automatic logic [SW-1:0] slot_of(logic [SW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return SW'(sum);
  endfunction

  logic [OP_W-1:0]    op_q;
  logic [DW-1:0]      val_q;
  logic [POS_W-1:0]   pos_q;
  logic [SHIFT_W-1:0] k_q;

  logic [SW-1:0]      first_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      idx_q;
  logic               fnd_q;

  logic [DW-1:0]      mem_q [CAPACITY];
  logic [DW-1:0]      rdata_q;

  logic               wr_en;
  logic [SW-1:0]      wr_addr;
  logic [DW-1:0]      wr_data;
  logic [SW-1:0]      rd_addr;
  logic [CW-1:0]      rd_off;
  logic [CW-1:0]      rot_off;

  logic               mod_done;
  logic [CW-1:0]      mod_rem;

  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic                found_q;
  logic [COUNT_W-1:0]  count_after_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      val_q <= {real_part_i, imag_part_i};
      pos_q <= position_i;
      k_q   <= shift_amount_i;
    end
  end

  olr_mod #(
    .VW (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (k_q),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // right rotation is a left one by (count - r) mod count
  always_comb begin
    if (op_q == OP_ROT_R && mod_rem != '0) begin
      rot_off = count_q - mod_rem;
    end else if (op_q == OP_ROT_R) begin
      rot_off = '0;
    end else begin
      rot_off = mod_rem;
    end
  end

  assign rd_off  = cmd_i.rd_next ? CW'(idx_q + CW'(1)) : idx_q;
  assign rd_addr = slot_of(first_q, rd_off);
  assign wr_en   = cmd_i.app_wr | cmd_i.shift_wr;
  assign wr_addr = cmd_i.app_wr ? slot_of(first_q, count_q) : slot_of(first_q, idx_q);
  assign wr_data = cmd_i.app_wr ? val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
      fnd_q   <= 1'b0;
    end else begin
      if (cmd_i.app_wr) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.rot_apply) begin
        first_q <= slot_of(first_q, rot_off);
      end
      if (cmd_i.idx_pos) begin
        idx_q <= CW'(PW'(pos_q) - PW'(1));
      end else if (cmd_i.idx_zero) begin
        idx_q <= '0;
      end else if (cmd_i.shift_wr || cmd_i.srch_cmp) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.load) begin
        fnd_q <= 1'b0;
      end else if (cmd_i.srch_cmp && rdata_q == val_q) begin
        fnd_q <= 1'b1;
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.op         = op_q;
    sts_o.empty      = (count_q == '0);
    sts_o.full       = (count_q >= CW'(CAPACITY));
    sts_o.pos_bad    = (pos_q == '0) || (PW'(pos_q) > PW'(count_q));
    sts_o.shift_more = ((CW+1)'(idx_q) + (CW+1)'(1)) < (CW+1)'(count_q);
    sts_o.srch_more  = !fnd_q && (idx_q < count_q);
    sts_o.mod_done   = mod_done;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q      <= cmd_i.res_status;
      found_q       <= fnd_q;
      count_after_q <= COUNT_W'(count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign count_after_o = count_after_q;

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CW'(CAPACITY), "entry count beyond capacity")
  `ASSERT_IMPLY(a_no_append_full, clk_i, rst_ni, cmd_i.app_wr, count_q < CW'(CAPACITY), "append into a full store")

endmodule

`default_nettype wire

FILE: rtl/ordered_list_engine_with_rotation_top.sv
`default_nettype none

// Channel | Dir | Modport | Payload
// --------+-----+---------+----------------------------------------------------
// in_i    | in  | sink    | opcode, real_part, imag_part, position, shift_amount
// out_o   | out | source  | status, found, count_after
//
// One request at a time; a new one is taken while the previous result waits.
// Append, remove-last, bad position and empty cases go from dispatch straight to the
// final state; remove-at walks the tail one moved entry at a time (a read state, then
// a write state); search reads, then compares, each entry in turn up to a hit.
// Rotation waits on the bit-serial 31-step remainder of k by the count.
// Reset clears head slot and count; store contents stay undefined until written.
// A stalled result holds the controller in its final state until taken.
module ordered_list_engine_with_rotation_top
  import olr_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  olr_in_if.sink     in_i,
  olr_out_if.source  out_o
);

  olr_cmd_t cmd;
  olr_sts_t sts;
  logic     in_ready;

  // Controller: sequencing only, sees the datapath through status flags.
  olr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // Datapath: store, head slot, count, walk index, remainder unit, result reg.
  olr_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (in_i.opcode),
    .real_part_i    (in_i.real_part),
    .imag_part_i    (in_i.imag_part),
    .position_i     (in_i.position),
    .shift_amount_i (in_i.shift_amount),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .status_o       (out_o.status),
    .found_o        (out_o.found),
    .count_after_o  (out_o.count_after)
  );

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import olr_pkg::*;

  localparam int unsigned CAP            = 64;
  localparam int unsigned IDLE_PCT       = 32;
  localparam int unsigned RANDOM_REQS    = 1700;
  localparam int unsigned PAUSE_EVERY    = 400;
  localparam int unsigned CALM_FROM      = 700;
  localparam int unsigned CALM_TO        = 1000;
  localparam int unsigned TAIL_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // opcodes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
    logic [POS_W-1:0]        pos;
    logic [SHIFT_W-1:0]      k;
  } list_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  count_after;
  } list_result_t;

  typedef struct packed {
    list_req_t    req;
    logic         typed;
    list_result_t want;
  } dir_row_t;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  olr_in_if  in_if ();
  olr_out_if out_if ();

  ordered_list_engine_with_rotation_top #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the list, in the same circular layout as the block.
  logic [VAL_W-1:0] lst_re [CAP];
  logic [VAL_W-1:0] lst_im [CAP];
  int unsigned      head;
  int unsigned      cnt;

  list_result_t result_q [$];
  dir_row_t     dir_q [$];
  int unsigned  mismatches = 0;
  int unsigned  reqs_sent;
  int unsigned  idle_cycles = 0;
  bit           calm;

  function automatic int unsigned slot_at(input int unsigned off);
    return (head + off) % CAP;
  endfunction

  // Applies one request to the shadow list and returns its result.
  function automatic list_result_t list_apply(input list_req_t r);
    list_result_t res;
    int unsigned  i;
    int unsigned  shift;
    res = '0;
    case (r.op)
      OP_APPEND: begin
        if (cnt >= CAP) begin
          res.status = ST_FULL;
        end else begin
          lst_re[slot_at(cnt)] = r.re;
          lst_im[slot_at(cnt)] = r.im;
          cnt++;
        end
      end
      OP_REM_LAST: begin
        if (cnt == 0) res.status = ST_EMPTY;
        else cnt--;
      end
      OP_REM_AT: begin
        if (cnt == 0) begin
          res.status = ST_EMPTY;
        end else if (r.pos == 0 || r.pos > cnt) begin
          res.status = ST_RANGE;
        end else begin
          for (i = r.pos - 1; i + 1 < cnt; i++) begin
            lst_re[slot_at(i)] = lst_re[slot_at(i + 1)];
            lst_im[slot_at(i)] = lst_im[slot_at(i + 1)];
          end
          cnt--;
        end
      end
      OP_ROT_L, OP_ROT_R: begin
        if (cnt == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shift = r.k % cnt;
          if (r.op == OP_ROT_R) shift = (cnt - shift) % cnt;
          head = slot_at(shift);
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < cnt && !res.found; i++) begin
          if (lst_re[slot_at(i)] == r.re && lst_im[slot_at(i)] == r.im) res.found = 1'b1;
        end
      end
      default: ;
    endcase
    res.count_after = COUNT_W'(cnt);
    return res;
  endfunction

  function automatic dir_row_t row(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] re,
                                   input logic [VAL_W-1:0] im, input logic [POS_W-1:0] pos,
                                   input logic [SHIFT_W-1:0] k, input logic typed,
                                   input logic [STATUS_W-1:0] st, input logic fnd,
                                   input logic [COUNT_W-1:0] n);
    dir_row_t d;
    d.req   = '{op: op, re: re, im: im, pos: pos, k: k};
    d.typed = typed;
    d.want  = '{status: st, found: fnd, count_after: n};
    return d;
  endfunction

  // Values lean on the extremes and on small numbers so that duplicates turn up.
  function automatic logic [VAL_W-1:0] any_word();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      4: return VAL_W'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  function automatic list_req_t next_req(input burst_e b);
    list_req_t   r;
    int unsigned roll;
    int unsigned s;
    r.op  = OP_APPEND;
    r.re  = any_word();
    r.im  = any_word();
    r.pos = POS_W'($urandom_range(127));
    r.k   = SHIFT_W'($urandom());
    roll  = $urandom_range(99);
    case (b)
      BURST_FILL: r.op = OP_APPEND;
      BURST_DRAIN: begin
        r.op = (roll < 40) ? OP_REM_LAST : OP_REM_AT;
        if (cnt > 0) r.pos = POS_W'($urandom_range(cnt, 1));
      end
      default: begin
        if (roll < 28) r.op = OP_APPEND;
        else if (roll < 36) r.op = OP_REM_LAST;
        else if (roll < 50) r.op = OP_REM_AT;
        else if (roll < 62) r.op = OP_ROT_L;
        else if (roll < 74) r.op = OP_ROT_R;
        else if (roll < 95) r.op = OP_SEARCH;
        else r.op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
        roll = $urandom_range(99);
        case (r.op)
          OP_REM_AT: begin
            if (roll < 75 && cnt > 0) r.pos = POS_W'($urandom_range(cnt, 1));
            else if (roll < 85) r.pos = '0;
            else if (roll < 92) r.pos = POS_W'(cnt + 1);
          end
          OP_ROT_L, OP_ROT_R: begin
            if (roll < 40) r.k = SHIFT_W'($urandom_range(150));
            else if (roll < 55) r.k = SHIFT_W'(cnt * $urandom_range(5));
            else if (roll < 62) r.k = '0;
          end
          OP_SEARCH: begin
            // mostly hits, some near misses that differ in one part only
            if (roll < 65 && cnt > 0) begin
              s    = slot_at($urandom_range(cnt - 1));
              r.re = lst_re[s];
              r.im = lst_im[s];
              if (roll < 10) r.im = r.im ^ VAL_W'(1 << $urandom_range(31));
              else if (roll < 15) r.re = r.re ^ VAL_W'(1 << $urandom_range(31));
            end
          end
          default: ;
        endcase
      end
    endcase
    return r;
  endfunction

  // Drives one request, waits for it to be taken, then records the expected result.
  task automatic send_req(input list_req_t r, input logic typed, input list_result_t want);
    list_result_t pred;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while (!calm && $urandom_range(99) < IDLE_PCT);
    end
    in_if.valid        <= 1'b1;
    in_if.opcode       <= r.op;
    in_if.real_part    <= r.re;
    in_if.imag_part    <= r.im;
    in_if.position     <= r.pos;
    in_if.shift_amount <= r.k;
    do @(posedge clk_i); while (!in_if.ready);
    pred = list_apply(r);
    result_q.push_back(typed ? want : pred);
    reqs_sent++;
  endtask

  // Sender holds off until every outstanding result has been taken.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (result_q.size() != 0);
  endtask

  // Result side: random back-pressure and in-order comparison.
  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (result_q.size() == 0) begin
        $error("result with nothing outstanding: status %0d found %0d count %0d",
               out_if.status, out_if.found, out_if.count_after);
        mismatches++;
      end else begin
        want = result_q.pop_front();
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          mismatches++;
        end
        if (out_if.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_if.found);
          mismatches++;
        end
        if (out_if.count_after !== want.count_after) begin
          $error("count_after: expected %0d, got %0d", want.count_after, out_if.count_after);
          mismatches++;
        end
      end
    end
    out_if.ready <= rst_ni && (calm || ($urandom_range(99) >= IDLE_PCT));
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t    d;
    burst_e      b;
    int unsigned n;
    int unsigned next_pause;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.opcode       = '0;
    in_if.real_part    = '0;
    in_if.imag_part    = '0;
    in_if.position     = '0;
    in_if.shift_amount = '0;
    reqs_sent          = 0;
    calm               = 1'b0;
    head               = 0;
    cnt                = 0;
    for (int i = 0; i < CAP; i++) begin
      lst_re[i] = '0;
      lst_im[i] = '0;
    end

    // Directed table; typed expectations only where obvious.
    dir_q.push_back(row(OP_REM_LAST, 0, 0, 0, 0, 1, ST_EMPTY, 0, 0));
    dir_q.push_back(row(OP_REM_AT, 0, 0, 1, 0, 1, ST_EMPTY, 0, 0));
    dir_q.push_back(row(OP_ROT_L, 0, 0, 0, 5, 1, ST_EMPTY, 0, 0));
    dir_q.push_back(row(OP_ROT_R, 0, 0, 0, 5, 1, ST_EMPTY, 0, 0));
    dir_q.push_back(row(OP_SEARCH, 0, 0, 0, 0, 1, ST_DONE, 0, 0));
    dir_q.push_back(row(OP_SPARE_6, '1, '1, '1, '1, 1, ST_DONE, 0, 0));
    dir_q.push_back(row(OP_SPARE_7, '1, '1, '1, '1, 1, ST_DONE, 0, 0));
    dir_q.push_back(row(OP_APPEND, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 1, ST_DONE, 0, 1));
    dir_q.push_back(row(OP_APPEND, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 1, ST_DONE, 0, 2));
    dir_q.push_back(row(OP_APPEND, 0, 0, 0, 0, 1, ST_DONE, 0, 3));
    dir_q.push_back(row(OP_APPEND, '1, '1, 0, 0, 1, ST_DONE, 0, 4));
    dir_q.push_back(row(OP_REM_AT, 0, 0, 0, 0, 1, ST_RANGE, 0, 4));
    dir_q.push_back(row(OP_REM_AT, 0, 0, 5, 0, 1, ST_RANGE, 0, 4));
    dir_q.push_back(row(OP_REM_AT, 0, 0, 7'd127, 0, 1, ST_RANGE, 0, 4));
    dir_q.push_back(row(OP_SEARCH, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(row(OP_SEARCH, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(row(OP_ROT_L, 0, 0, 0, 31'h7fff_ffff, 0, 0, 0, 0));
    dir_q.push_back(row(OP_ROT_R, 0, 0, 0, 0, 1, ST_DONE, 0, 4));
    dir_q.push_back(row(OP_ROT_L, 0, 0, 0, 4, 1, ST_DONE, 0, 4));
    dir_q.push_back(row(OP_ROT_R, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_q.push_back(row(OP_SEARCH, '1, '1, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(row(OP_REM_AT, 0, 0, 1, 0, 0, 0, 0, 0));
    dir_q.push_back(row(OP_REM_AT, 0, 0, 3, 0, 0, 0, 0, 0));
    dir_q.push_back(row(OP_REM_LAST, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(row(OP_SEARCH, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[i]) begin
      d = dir_q[i];
      send_req(d.req, d.typed, d.want);
    end
    drain_results();

    // Random bursts: fill to full, drain to empty, or a mixed run.
    next_pause = reqs_sent + PAUSE_EVERY;
    while (reqs_sent < dir_q.size() + RANDOM_REQS) begin
      calm = (reqs_sent >= CALM_FROM && reqs_sent < CALM_TO);
      n    = $urandom_range(99);
      b    = (n < 15) ? BURST_FILL : (n < 30) ? BURST_DRAIN : BURST_MIXED;
      case (b)
        BURST_FILL: begin
          while (cnt < CAP) send_req(next_req(b), 1'b0, '0);
          repeat ($urandom_range(3, 1)) send_req(next_req(b), 1'b0, '0);
        end
        BURST_DRAIN: begin
          while (cnt > 0) send_req(next_req(b), 1'b0, '0);
          repeat ($urandom_range(2, 1)) send_req(next_req(b), 1'b0, '0);
        end
        default: begin
          repeat ($urandom_range(40, 10)) send_req(next_req(b), 1'b0, '0);
        end
      endcase
      if (reqs_sent >= next_pause) begin
        drain_results();
        next_pause = reqs_sent + PAUSE_EVERY;
      end
    end
    calm = 1'b0;

    in_if.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
